/* src/alm_pkg.sv */
// shared constants and codes of the array linked list manager
`default_nettype none

package alm_pkg;

    // default sizes
    localparam int CAPACITY_DEF   = 255;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes on the input tuser
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_FIND   = 2'd2;

    // status codes on the output tuser
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

endpackage

`default_nettype wire

/* src/alm_ram.sv */
// generic single-port ram with registered read
`default_nettype none

module alm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, or read into the output register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/alm_link_view.sv */
// decodes a link word, supplying the reset free chain for entries not yet written
`default_nettype none

module alm_link_view #(
    parameter int CAPACITY = 255,
    localparam int SW = $clog2(CAPACITY + 1)
) (
    input  wire logic [SW-1:0] addr,      // entry the word was read from
    input  wire logic [SW:0]   raw,       // {member, next} as stored
    input  wire logic [SW:0]   fill,      // entries below this one were written
    input  wire logic          head_wr,   // sentinel entry was written
    output logic      [SW-1:0] next_slot,
    output logic               member
);

    logic          written;
    logic [SW-1:0] fresh_next;

    // entries at or above the fill mark still hold the initial chain
    always_comb begin
        if (addr == '0) begin
            written = head_wr;
        end else begin
            written = ({1'b0, addr} < fill);
        end
        if (addr == '0 || addr == SW'(CAPACITY)) begin
            fresh_next = '0;
        end else begin
            fresh_next = SW'(addr + SW'(1));
        end
        next_slot = written ? raw[SW-1:0] : fresh_next;
        member    = written && raw[SW] && (addr != '0);
    end

endmodule

`default_nettype wire

/* src/array_linked_list_manager_top.sv */
// top level of the array doubly linked list manager with free chain
//
// Input channel s_*: one transaction is one operation. s_tuser[1:0] holds the
// operation (insert after slot, remove slot, find value), s_tdata holds the
// slot and the value. Output channel m_*: one transaction per operation, with
// the status in m_tuser and the result slot and element count in m_tdata.
// Operations are processed one at a time by a sequencer around three
// single-port rams (next link with membership, previous link, element value).
// An insert reads the anchor and the free head, pops the free chain and links
// the new entry; a remove reads and unlinks the slot; a find reads one link
// ram word per element visited. Operations rejected up front (full, empty,
// slot out of range, unused code) or whose slot is not in the list end early.
// s_tready is high only while the sequencer is idle; the next operation can be
// taken in the cycle after the result is loaded into the output register.
// Reset (aresetn low, synchronous) empties the list and rebuilds the free
// chain at once through a fill mark, so there is no clearing pass.
// A stalled receiver holds the result in the output register; a finished
// operation waits in the sequencer until the register is free.
`default_nettype none

module array_linked_list_manager_top #(
    parameter int CAPACITY   = alm_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = alm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input transactions
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // slot[7:0], value[39:8]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    // result transactions
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // result_slot[7:0], element_count[15:8]
    output logic      [1:0]  m_tuser    // status[1:0]
);

    localparam int NSLOTS = CAPACITY + 1;
    localparam int SW     = $clog2(NSLOTS);
    localparam int DW     = DATA_WIDTH;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_INS_RD = 8'b00000010,
        ST_INS_FH = 8'b00000100,
        ST_INS_WB = 8'b00001000,
        ST_REM_RD = 8'b00010000,
        ST_REM_WB = 8'b00100000,
        ST_WALK   = 8'b01000000,
        ST_RESP   = 8'b10000000
    } state_t;

    // control registers
    state_t        state_reg, state_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [SW-1:0] free_head_reg, free_head_next;
    logic [SW-1:0] count_reg, count_next;
    logic [SW:0]   fill_reg, fill_next;
    logic          head_wr_reg, head_wr_next;

    // payload registers
    logic [SW-1:0] slot_reg, slot_next;
    logic [DW-1:0] value_reg, value_next;
    logic [SW-1:0] nx_reg, nx_next;
    logic [SW-1:0] ent_reg, ent_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] res_reg, res_next;
    logic [1:0]    status_reg, status_next;
    logic [SW-1:0] rd_addr_reg;
    logic [1:0]    m_status_reg, m_status_next;
    logic [7:0]    m_slot_reg, m_slot_next;
    logic [7:0]    m_count_reg, m_count_next;

    // ram ports
    logic          lk_we, pv_we, el_we;
    logic [SW-1:0] lk_addr, pv_addr, el_addr;
    logic [SW:0]   lk_wdata, lk_rdata;
    logic [SW-1:0] pv_wdata, pv_rdata;
    logic [DW-1:0] el_wdata, el_rdata;

    // decoded link word of the last read
    logic [SW-1:0] vw_next;
    logic          vw_member;

    // input fields
    logic [1:0]    in_func;
    logic [7:0]    in_slot;
    logic [31:0]   in_value;
    logic [SW-1:0] in_idx;
    logic          in_range;

    assign in_func  = s_tuser[1:0];
    assign in_slot  = s_tdata[7:0];
    assign in_value = s_tdata[39:8];
    assign in_idx   = SW'(in_slot);
    assign in_range = (32'(in_slot) < 32'(NSLOTS));

    alm_ram #(.WIDTH(SW + 1), .DEPTH(NSLOTS)) u_link_ram (
        .aclk  (aclk),
        .we    (lk_we),
        .addr  (lk_addr),
        .wdata (lk_wdata),
        .rdata (lk_rdata)
    );

    alm_ram #(.WIDTH(SW), .DEPTH(NSLOTS)) u_prev_ram (
        .aclk  (aclk),
        .we    (pv_we),
        .addr  (pv_addr),
        .wdata (pv_wdata),
        .rdata (pv_rdata)
    );

    alm_ram #(.WIDTH(DW), .DEPTH(NSLOTS)) u_elem_ram (
        .aclk  (aclk),
        .we    (el_we),
        .addr  (el_addr),
        .wdata (el_wdata),
        .rdata (el_rdata)
    );

    alm_link_view #(.CAPACITY(CAPACITY)) u_link_view (
        .addr      (rd_addr_reg),
        .raw       (lk_rdata),
        .fill      (fill_reg),
        .head_wr   (head_wr_reg),
        .next_slot (vw_next),
        .member    (vw_member)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        head_wr_next   = head_wr_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        nx_next        = nx_reg;
        ent_next       = ent_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_slot_next    = m_slot_reg;
        m_count_next   = m_count_reg;

        lk_we    = 1'b0;
        lk_addr  = slot_reg;
        lk_wdata = '0;
        pv_we    = 1'b0;
        pv_addr  = slot_reg;
        pv_wdata = '0;
        el_we    = 1'b0;
        el_addr  = slot_reg;
        el_wdata = value_reg;

        case (state_reg)
            ST_IDLE: begin
                // read the addressed links while waiting for a transaction
                lk_addr = (in_func == alm_pkg::FUNC_FIND) ? '0 : in_idx;
                pv_addr = in_idx;
                el_addr = in_idx;
                if (s_tvalid) begin
                    slot_next   = in_idx;
                    value_next  = DW'(in_value);
                    cur_next    = '0;
                    res_next    = '0;
                    status_next = alm_pkg::STATUS_OK;
                    case (in_func)
                        alm_pkg::FUNC_INSERT: begin
                            if (count_reg == SW'(CAPACITY)) begin
                                status_next = alm_pkg::STATUS_FULL;
                                state_next  = ST_RESP;
                            end else if (in_slot != 8'd0 && !in_range) begin
                                status_next = alm_pkg::STATUS_BAD_SLOT;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_INS_RD;
                            end
                        end
                        alm_pkg::FUNC_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = alm_pkg::STATUS_EMPTY;
                                state_next  = ST_RESP;
                            end else if (in_slot == 8'd0 || !in_range) begin
                                status_next = alm_pkg::STATUS_BAD_SLOT;
                                state_next  = ST_RESP;
                            end else begin
                                state_next = ST_REM_RD;
                            end
                        end
                        alm_pkg::FUNC_FIND: begin
                            state_next = ST_WALK;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_INS_RD: begin
                // check the anchor slot, fetch the link of the free head
                lk_addr = free_head_reg;
                if (slot_reg != '0 && !vw_member) begin
                    status_next = alm_pkg::STATUS_BAD_SLOT;
                    state_next  = ST_RESP;
                end else begin
                    nx_next    = vw_next;
                    ent_next   = free_head_reg;
                    state_next = ST_INS_FH;
                end
            end

            ST_INS_FH: begin
                // pop the free chain, link anchor to new entry, store value
                free_head_next = vw_next;
                lk_we    = 1'b1;
                lk_addr  = slot_reg;
                lk_wdata = {slot_reg != '0, ent_reg};
                pv_we    = 1'b1;
                pv_addr  = nx_reg;
                pv_wdata = ent_reg;
                el_we    = 1'b1;
                el_addr  = ent_reg;
                state_next = ST_INS_WB;
            end

            ST_INS_WB: begin
                // links of the new entry
                lk_we    = 1'b1;
                lk_addr  = ent_reg;
                lk_wdata = {1'b1, nx_reg};
                pv_we    = 1'b1;
                pv_addr  = ent_reg;
                pv_wdata = slot_reg;
                count_next = SW'(count_reg + SW'(1));
                res_next   = ent_reg;
                state_next = ST_RESP;
            end

            ST_REM_RD: begin
                // unlink: push slot on the free chain, fix prev of successor
                if (!vw_member) begin
                    status_next = alm_pkg::STATUS_BAD_SLOT;
                    state_next  = ST_RESP;
                end else begin
                    lk_we    = 1'b1;
                    lk_addr  = slot_reg;
                    lk_wdata = {1'b0, free_head_reg};
                    pv_we    = 1'b1;
                    pv_addr  = vw_next;
                    pv_wdata = pv_rdata;
                    nx_next  = vw_next;
                    ent_next = pv_rdata;
                    free_head_next = slot_reg;
                    state_next = ST_REM_WB;
                end
            end

            ST_REM_WB: begin
                // next of predecessor skips the removed slot
                lk_we    = 1'b1;
                lk_addr  = ent_reg;
                lk_wdata = {ent_reg != '0, nx_reg};
                count_next = SW'(count_reg - SW'(1));
                res_next   = slot_reg;
                state_next = ST_RESP;
            end

            ST_WALK: begin
                // one element per cycle, next read issued from the link just read
                lk_addr = vw_next;
                el_addr = vw_next;
                if (cur_reg != '0 && el_rdata == value_reg) begin
                    res_next   = cur_reg;
                    state_next = ST_RESP;
                end else if (vw_next == '0) begin
                    state_next = ST_RESP;
                end else begin
                    cur_next = vw_next;
                end
            end

            ST_RESP: begin
                // hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = 8'(res_reg);
                    m_count_next  = 8'(count_reg);
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // fill mark and sentinel flag follow the link writes
        if (lk_we) begin
            if (lk_addr == '0) begin
                head_wr_next = 1'b1;
            end else if ({1'b0, lk_addr} == fill_reg) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            free_head_reg <= SW'(1);
            count_reg     <= '0;
            fill_reg      <= (SW + 1)'(1);
            head_wr_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            head_wr_reg   <= head_wr_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        value_reg    <= value_next;
        nx_reg       <= nx_next;
        ent_reg      <= ent_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        rd_addr_reg  <= lk_addr;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_count_reg  <= m_count_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_count_reg, m_slot_reg};
    assign m_tuser  = m_status_reg;

endmodule

`default_nettype wire

/* src/alm_checker.sv */
// port-level checks of the array linked list manager, bound to the top level
`default_nettype none

module alm_checker #(
    parameter int CAPACITY = alm_pkg::CAPACITY_DEF
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one operation at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second operation accepted while busy");

    // a rejected operation names no slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != alm_pkg::STATUS_OK |-> m_tdata[7:0] == 8'd0)
        else $error("error result carries a slot");

    // full is only reported with the list at capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == alm_pkg::STATUS_FULL |-> m_tdata[15:8] == 8'(CAPACITY))
        else $error("full reported below capacity");

    // empty is only reported with no elements
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == alm_pkg::STATUS_EMPTY |-> m_tdata[15:8] == 8'd0)
        else $error("empty reported with elements");

endmodule

bind array_linked_list_manager_top alm_checker #(.CAPACITY(CAPACITY)) u_alm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* verif/array_linked_list_manager_top_test.sv */
// self-checking testbench of the array linked list manager: stream driving and slot list tracking
`default_nettype none

module array_linked_list_manager_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_CAP    = alm_pkg::CAPACITY_DEF;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          TOTAL_OPS   = 1350;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot;
        logic [7:0] elems;
    } list_result_t;

    // tracks the slot arrays, the free chain and the results still owed
    class slot_list_tracker;
        logic [31:0]  stored_value [256];
        logic [7:0]   fwd_link [256];
        logic [7:0]   back_link [256];
        bit           linked [256];
        logic [7:0]   free_top;
        logic [7:0]   used;
        list_result_t awaited_results[$];
        int           mismatches;

        function new();
            for (int i = 0; i < 256; i++) begin
                stored_value[i] = '0;
                back_link[i]    = '0;
                linked[i]       = 1'b0;
                fwd_link[i]     = (i == 0 || i == LIST_CAP) ? 8'd0 : 8'(i + 1);
            end
            free_top   = 8'd1;
            used       = 8'd0;
            mismatches = 0;
        endfunction

        // work out the result of one accepted operation and update the list
        function void apply_op(logic [1:0] op, logic [7:0] at, logic [31:0] val);
            list_result_t r;
            logic [7:0]   e;
            logic [7:0]   nx;
            logic [7:0]   p;
            logic [7:0]   walk;
            int           steps;
            r = '0;
            case (op)
                alm_pkg::FUNC_INSERT: begin
                    if (used >= LIST_CAP) begin
                        r.status = alm_pkg::STATUS_FULL;
                    end else if (at != 0 && !linked[at]) begin
                        r.status = alm_pkg::STATUS_BAD_SLOT;
                    end else begin
                        e               = free_top;
                        nx              = fwd_link[at];
                        free_top        = fwd_link[e];
                        stored_value[e] = val;
                        fwd_link[at]    = e;
                        back_link[nx]   = e;
                        fwd_link[e]     = nx;
                        back_link[e]    = at;
                        linked[e]       = 1'b1;
                        used++;
                        r.slot = e;
                    end
                end
                alm_pkg::FUNC_REMOVE: begin
                    if (used == 0) begin
                        r.status = alm_pkg::STATUS_EMPTY;
                    end else if (at == 0 || !linked[at]) begin
                        r.status = alm_pkg::STATUS_BAD_SLOT;
                    end else begin
                        p             = back_link[at];
                        nx            = fwd_link[at];
                        fwd_link[at]  = free_top;
                        back_link[at] = 8'd0;
                        free_top      = at;
                        fwd_link[p]   = nx;
                        back_link[nx] = p;
                        linked[at]    = 1'b0;
                        used--;
                        r.slot = at;
                    end
                end
                alm_pkg::FUNC_FIND: begin
                    // first match counted from the head
                    walk  = fwd_link[0];
                    steps = 0;
                    while (walk != 0 && steps < LIST_CAP) begin
                        if (stored_value[walk] == val) begin
                            r.slot = walk;
                            break;
                        end
                        walk = fwd_link[walk];
                        steps++;
                    end
                end
                default: ;
            endcase
            r.elems = used;
            awaited_results.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void compare_result(list_result_t got);
            list_result_t want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result, got status %0d slot %0d count %0d",
                         $time, got.status, got.slot, got.elems);
                return;
            end
            want = awaited_results.pop_front();
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("result_slot", want.slot, got.slot);
            check_field("element_count", want.elems, got.elems);
        endfunction

        // random slot that is in the list, or the sentinel when empty
        function logic [7:0] pick_member();
            logic [7:0] members[$];
            for (int i = 1; i < 256; i++)
                if (linked[i])
                    members.push_back(8'(i));
            if (members.size() == 0)
                return 8'd0;
            return members[$urandom_range(0, members.size() - 1)];
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // slot[7:0], value[39:8]
    logic [1:0]  s_tuser  = '0;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // result_slot[7:0], element_count[15:8]
    logic [1:0]  m_tuser;         // status[1:0]

    slot_list_tracker tracker = new();
    int               ops_sent     = 0;
    int               results_seen = 0;

    array_linked_list_manager_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #6 aclk = ~aclk;

    // run limit
    initial begin
        #(30_000_000);
        $display("Mismatches found");
        $finish;
    end

    // check every accepted result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.compare_result({m_tuser, m_tdata[7:0], m_tdata[15:8]});
            results_seen++;
        end
    end

    // result side ready: random stalls, one long hold-off, one stall-free stretch
    initial begin
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 250) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            if (results_seen >= 500 && results_seen < 700)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 10);
        end
    end

    function automatic logic [31:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return 32'($urandom_range(0, 7));
        if (pick < 30)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // offer one operation and wait for its transaction
    task automatic send_op(logic [1:0] op, logic [7:0] at, logic [31:0] val);
        @(negedge aclk);
        while (!(ops_sent >= 300 && ops_sent < 500) && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, at};
        do @(posedge aclk); while (!s_tready);
        tracker.apply_op(op, at, val);
        ops_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_all_results();
        while (tracker.awaited_results.size() != 0)
            @(posedge aclk);
    endtask

    // one random operation, mostly on slots and values already in the list
    task automatic random_op(int ins_pct, int rem_pct);
        int         pick;
        logic [7:0] at;
        logic [31:0] val;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
        end else if (pick < 8 + ins_pct) begin
            at = ($urandom_range(0, 4) == 0) ? 8'd0 : tracker.pick_member();
            send_op(alm_pkg::FUNC_INSERT, at, random_value());
        end else if (pick < 8 + ins_pct + rem_pct) begin
            send_op(alm_pkg::FUNC_REMOVE, tracker.pick_member(), random_value());
        end else begin
            at  = tracker.pick_member();
            val = ($urandom_range(0, 1) != 0 && at != 0) ? tracker.stored_value[at]
                                                          : random_value();
            send_op(alm_pkg::FUNC_FIND, 8'($urandom_range(0, 255)), val);
        end
    endtask

    // stimulus
    initial begin
        int guard;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty list cases
        send_op(alm_pkg::FUNC_FIND,   8'd0,   32'd0);
        send_op(alm_pkg::FUNC_REMOVE, 8'd5,   32'd0);
        send_op(FUNC_UNUSED,          8'd0,   32'd0);
        send_op(alm_pkg::FUNC_INSERT, 8'd7,   32'h1111_1111);
        // directed: build a short list with a repeated value
        send_op(alm_pkg::FUNC_INSERT, 8'd0,   32'd0);
        send_op(alm_pkg::FUNC_INSERT, 8'd0,   32'hFFFF_FFFF);
        send_op(alm_pkg::FUNC_INSERT, 8'd1,   32'hA5A5_A5A5);
        send_op(alm_pkg::FUNC_INSERT, 8'd2,   32'd0);
        send_op(alm_pkg::FUNC_FIND,   8'd0,   32'd0);
        send_op(alm_pkg::FUNC_FIND,   8'd255, 32'hFFFF_FFFF);
        send_op(alm_pkg::FUNC_FIND,   8'd0,   32'h1234_5678);
        // directed: bad slots, removal at head, tail and middle, slot reuse
        send_op(alm_pkg::FUNC_REMOVE, 8'd0,   32'd0);
        send_op(alm_pkg::FUNC_REMOVE, 8'd255, 32'd0);
        send_op(alm_pkg::FUNC_REMOVE, 8'd4,   32'd0);
        send_op(alm_pkg::FUNC_REMOVE, 8'd4,   32'd0);
        send_op(alm_pkg::FUNC_INSERT, 8'd4,   32'h0F0F_0F0F);
        send_op(FUNC_UNUSED,          8'd255, 32'hFFFF_FFFF);
        send_op(alm_pkg::FUNC_REMOVE, 8'd3,   32'd0);
        send_op(alm_pkg::FUNC_INSERT, 8'd2,   32'h5A5A_5A5A);
        send_op(alm_pkg::FUNC_REMOVE, 8'd2,   32'd0);
        send_op(alm_pkg::FUNC_FIND,   8'd0,   32'h5A5A_5A5A);
        stop_sending();
        wait_all_results();

        // random rounds: grow, fill past full, churn at the top, drain past empty
        while (ops_sent < TOTAL_OPS) begin
            repeat (120) random_op(60, 15);
            guard = 0;
            while (tracker.used < LIST_CAP && guard < 1500) begin
                random_op(85, 3);
                guard++;
            end
            repeat (3) send_op(alm_pkg::FUNC_INSERT, tracker.pick_member(), random_value());
            repeat (60) random_op(40, 40);
            guard = 0;
            while (tracker.used != 0 && guard < 1500) begin
                random_op(3, 85);
                guard++;
            end
            repeat (2) send_op(alm_pkg::FUNC_REMOVE, 8'($urandom_range(0, 255)),
                               random_value());
            stop_sending();
            wait_all_results();
        end

        // let any stray result show up
        repeat (300) @(posedge aclk);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
